### rtl/core/utd_pkg.sv
`timescale 1ns / 1ps

package utd_pkg;

    localparam int unsigned CP_W    = 21;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CNT_W   = 2;

    // lead byte class boundaries
    localparam logic [BYTE_W-1:0] LEAD1_MAX = 8'h7f;
    localparam logic [BYTE_W-1:0] LEAD2_MAX = 8'hdf;
    localparam logic [BYTE_W-1:0] LEAD3_MAX = 8'hef;
    localparam logic [BYTE_W-1:0] LEAD4_MAX = 8'hf7;

    // payload masks per lead class
    localparam logic [BYTE_W-1:0] MASK1    = 8'h7f;
    localparam logic [BYTE_W-1:0] MASK2    = 8'h1f;
    localparam logic [BYTE_W-1:0] MASK3    = 8'h0f;
    localparam logic [BYTE_W-1:0] MASK4    = 8'h07;
    localparam logic [BYTE_W-1:0] MASK_CONT = 8'h3f;

    // continuation bytes still expected after a lead
    localparam logic [CNT_W-1:0] REM_NONE  = 2'd0;
    localparam logic [CNT_W-1:0] REM_ONE   = 2'd1;
    localparam logic [CNT_W-1:0] REM_TWO   = 2'd2;
    localparam logic [CNT_W-1:0] REM_THREE = 2'd3;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    typedef struct packed {
        logic            valid;
        logic [CP_W-1:0] code_point;
        logic            status;
        logic            end_of_string;
    } t_result;

endpackage

### rtl/core/utd_step.sv
`timescale 1ns / 1ps

module utd_step (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic [utd_pkg::BYTE_W-1:0]  i_byte,
    input  logic                        i_last,
    output utd_pkg::t_result            o_res
);

    logic [utd_pkg::CNT_W-1:0] r_rem;
    logic [utd_pkg::CP_W-1:0]  r_pv;
    logic                      r_dropping;

    logic [utd_pkg::CNT_W-1:0] n_rem;
    logic [utd_pkg::CP_W-1:0]  n_pv;
    logic                      n_dropping;
    utd_pkg::t_result          res;
    logic [utd_pkg::CP_W-1:0]  shifted;

    localparam int unsigned CONT_W = 6;

    assign shifted = {r_pv[utd_pkg::CP_W-CONT_W-1:0], i_byte[CONT_W-1:0]};

    always_comb begin
        n_rem              = r_rem;
        n_pv               = r_pv;
        n_dropping         = r_dropping;
        res.valid          = 1'b0;
        res.code_point     = '0;
        res.status         = utd_pkg::ST_OK;
        res.end_of_string  = i_last;

        if (r_dropping) begin
            // swallow bytes until the string closes
            if (i_last) begin
                n_dropping = 1'b0;
            end
        end else if (r_rem != utd_pkg::REM_NONE) begin
            n_rem = r_rem - utd_pkg::REM_ONE;
            n_pv  = shifted;
            if (r_rem == utd_pkg::REM_ONE) begin
                res.valid      = 1'b1;
                res.code_point = shifted;
                n_pv           = '0;
            end else if (i_last) begin
                // truncated sequence
                res.valid         = 1'b1;
                res.status        = utd_pkg::ST_ERR;
                res.end_of_string = 1'b1;
                n_rem             = utd_pkg::REM_NONE;
                n_pv              = '0;
            end
        end else begin
            if (i_byte <= utd_pkg::LEAD1_MAX) begin
                res.valid      = 1'b1;
                res.code_point = utd_pkg::CP_W'(i_byte & utd_pkg::MASK1);
            end else if (i_byte > utd_pkg::LEAD4_MAX) begin
                // invalid lead
                res.valid         = 1'b1;
                res.status        = utd_pkg::ST_ERR;
                res.end_of_string = 1'b1;
                n_dropping        = !i_last;
            end else if (i_last) begin
                // multi-byte lead as final byte
                res.valid         = 1'b1;
                res.status        = utd_pkg::ST_ERR;
                res.end_of_string = 1'b1;
            end else if (i_byte <= utd_pkg::LEAD2_MAX) begin
                n_pv  = utd_pkg::CP_W'(i_byte & utd_pkg::MASK2);
                n_rem = utd_pkg::REM_ONE;
            end else if (i_byte <= utd_pkg::LEAD3_MAX) begin
                n_pv  = utd_pkg::CP_W'(i_byte & utd_pkg::MASK3);
                n_rem = utd_pkg::REM_TWO;
            end else begin
                n_pv  = utd_pkg::CP_W'(i_byte & utd_pkg::MASK4);
                n_rem = utd_pkg::REM_THREE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem      <= utd_pkg::REM_NONE;
            r_pv       <= '0;
            r_dropping <= 1'b0;
        end else if (i_fire) begin
            r_rem      <= n_rem;
            r_pv       <= n_pv;
            r_dropping <= n_dropping;
        end
    end

    assign o_res = '{valid:         res.valid & i_fire,
                     code_point:    res.code_point,
                     status:        res.status,
                     end_of_string: res.end_of_string};

    // no sequence is in flight while dropping
    a_drop_no_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dropping |-> (r_rem == utd_pkg::REM_NONE && r_pv == '0))
        else $error("sequence state left over while dropping");

    // dropped bytes never produce a result
    a_drop_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_dropping) |-> !o_res.valid)
        else $error("result produced while dropping");

    // an error result always closes the string with a zero code point
    a_err_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status == utd_pkg::ST_ERR)
            |-> (o_res.end_of_string && o_res.code_point == '0))
        else $error("error result without end of string or with data");

    // a string always ends with no sequence pending
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_last) |=> (r_rem == utd_pkg::REM_NONE && !r_dropping))
        else $error("state pending after end of string");

endmodule

### rtl/core/utf8_to_code_point_decoder.sv
`timescale 1ns / 1ps

// channel | direction | handshake                | payload
// --------+-----------+--------------------------+-------------------------------------------
// in      | input     | i_in_valid / o_in_ready  | i_data_byte[7:0], i_last_byte
// out     | output    | o_out_valid / i_out_ready| o_code_point[20:0], o_status,
//         |           |                          | o_end_of_string
//
// one byte per clock sustained while the output is not stalled; each item is held in the input register,
// and its result, if any, is registered in the output register
// the decode step (lead class, six-bit shift, error check) sits between the two registers
// reset (i_rst_n low, synchronous) empties both registers and clears the decoder state
// an output stall holds the result; one more item waits in the input register, then
// o_in_ready drops until the result is taken
module utf8_to_code_point_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [20:0] o_code_point,
    output logic        o_status,
    output logic        o_end_of_string
);

    // input register
    logic                       r_in_valid;
    logic [utd_pkg::BYTE_W-1:0] r_in_byte;
    logic                       r_in_last;

    // output register
    logic                       r_out_valid;
    logic [utd_pkg::CP_W-1:0]   r_out_cp;
    logic                       r_out_status;
    logic                       r_out_eos;

    logic             adv;
    logic             out_free;
    utd_pkg::t_result step_res;

    // output slot is free when empty or being drained this cycle
    assign out_free   = !r_out_valid || i_out_ready;
    // the held item is decoded when its result (if any) has a place to land
    assign adv        = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    // decoder state and per-byte decode
    utd_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (adv),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && step_res.valid) begin
            r_out_cp     <= step_res.code_point;
            r_out_status <= step_res.status;
            r_out_eos    <= step_res.end_of_string;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_code_point    = r_out_cp;
    assign o_status        = r_out_status;
    assign o_end_of_string = r_out_eos;

    // a stalled result is never overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out_cp)
            && $stable(r_out_status) && $stable(r_out_eos)))
        else $error("pending result overwritten");

    // a held item is never dropped while the output stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> (r_in_valid && $stable(r_in_byte)
            && $stable(r_in_last)))
        else $error("held item lost");

    // a reported error carries end of string
    a_out_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == utd_pkg::ST_ERR) |-> r_out_eos)
        else $error("error result does not close string");

endmodule
